// File: rtl/mp3d_pkg.sv
// Package for the 3D max pooling stream block.
// Shared types and constants; no dependencies.
`default_nettype none

package mp3d_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_POOL_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VOL_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VOL_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VOL_Z  = 3'd5;

    // Depth of the queue between the front and the back part.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    // Register file contents after range clamping.
    typedef struct packed {
        logic [6:0]  pool_x;
        logic [6:0]  pool_y;
        logic [6:0]  pool_z;
        logic [12:0] vol_x;
        logic [12:0] vol_y;
        logic [15:0] vol_z;
    } cfg_t;

    // Per-voxel control produced by the front part.
    typedef struct packed {
        logic        first;
        logic        emit;
        logic        last;
        logic [11:0] out_x;
        logic [11:0] out_y;
        logic [15:0] out_z;
    } ctl_t;

    // Sequencer states of the cell-count derivation.
    typedef enum logic [1:0] {
        CFG_IDLE,
        CFG_LOAD,
        CFG_DIV,
        CFG_RED
    } cfg_state_t;

endpackage

`default_nettype wire

// File: rtl/mp3d_cfg.sv
// Configuration registers and the derivation of the cells per output row.
// Depends on mp3d_pkg.
`default_nettype none

module mp3d_cfg #(
    parameter int MAX_PLANE_CELLS = 65536,
    parameter int MAX_POOL        = 64,
    parameter int MAX_EXTENT      = 4096
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [mp3d_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mp3d_pkg::CFG_DATA_W-1:0]  cfg_data,
    output mp3d_pkg::cfg_t                        cfg,
    output logic [((MAX_PLANE_CELLS > 2) ? $clog2(MAX_PLANE_CELLS) : 1)-1:0] cam,
    output logic                                  busy
);

    localparam int AW = (MAX_PLANE_CELLS > 2) ? $clog2(MAX_PLANE_CELLS) : 1;
    localparam int DIV_STEPS = 14;

    mp3d_pkg::cfg_t     cfg_reg;
    mp3d_pkg::cfg_state_t state_reg, state_next;
    logic [AW-1:0]      cam_reg;
    logic [13:0]        n_reg;
    logic [13:0]        q_reg;
    logic [6:0]         rem_reg;
    logic [3:0]         cnt_reg;

    logic               wr_hit;
    logic               do_load, do_step, do_red, do_done;
    logic [6:0]         pool_v;
    logic [6:0]         pool_c;
    logic [12:0]        vol_v;
    logic [12:0]        vol_c;
    logic [15:0]        volz_c;
    logic [7:0]         rem_sh;
    logic               ge;
    logic               q_big;

    // Range clamping of the incoming write data.
    assign pool_v = cfg_data[6:0];
    assign vol_v  = cfg_data[12:0];
    assign pool_c = (pool_v == 7'd0) ? 7'd1 :
                    ((32'(pool_v) > MAX_POOL) ? 7'(MAX_POOL) : pool_v);
    assign vol_c  = (vol_v == 13'd0) ? 13'd1 :
                    ((32'(vol_v) > MAX_EXTENT) ? 13'(MAX_EXTENT) : vol_v);
    assign volz_c = (cfg_data == 16'd0) ? 16'd1 : cfg_data;

    assign wr_hit = cfg_we && (cfg_index <= mp3d_pkg::REG_VOL_Z);

    // Register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pool_x <= 7'd1;
            cfg_reg.pool_y <= 7'd1;
            cfg_reg.pool_z <= 7'd1;
            cfg_reg.vol_x  <= 13'd1;
            cfg_reg.vol_y  <= 13'd1;
            cfg_reg.vol_z  <= 16'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mp3d_pkg::REG_POOL_X: cfg_reg.pool_x <= pool_c;
                mp3d_pkg::REG_POOL_Y: cfg_reg.pool_y <= pool_c;
                mp3d_pkg::REG_POOL_Z: cfg_reg.pool_z <= pool_c;
                mp3d_pkg::REG_VOL_X:  cfg_reg.vol_x  <= vol_c;
                mp3d_pkg::REG_VOL_Y:  cfg_reg.vol_y  <= vol_c;
                mp3d_pkg::REG_VOL_Z:  cfg_reg.vol_z  <= volz_c;
                default:              cfg_reg        <= cfg_reg;
            endcase
        end
    end

    // One restoring division step on the ceiling dividend.
    assign rem_sh = {rem_reg, n_reg[13]};
    assign ge     = rem_sh >= {1'b0, cfg_reg.pool_x};
    assign q_big  = 32'(q_reg) >= MAX_PLANE_CELLS;

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mp3d_pkg::CFG_IDLE: if (wr_hit) state_next = mp3d_pkg::CFG_LOAD;
            mp3d_pkg::CFG_LOAD: state_next = wr_hit ? mp3d_pkg::CFG_LOAD : mp3d_pkg::CFG_DIV;
            mp3d_pkg::CFG_DIV:
            begin
                if (wr_hit)
                    state_next = mp3d_pkg::CFG_LOAD;
                else if (cnt_reg == 4'(DIV_STEPS - 1))
                    state_next = mp3d_pkg::CFG_RED;
            end
            mp3d_pkg::CFG_RED:
            begin
                if (wr_hit)
                    state_next = mp3d_pkg::CFG_LOAD;
                else if (!q_big)
                    state_next = mp3d_pkg::CFG_IDLE;
            end
            default: state_next = mp3d_pkg::CFG_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        busy    = (state_reg != mp3d_pkg::CFG_IDLE);
        do_load = (state_reg == mp3d_pkg::CFG_LOAD);
        do_step = (state_reg == mp3d_pkg::CFG_DIV);
        do_red  = (state_reg == mp3d_pkg::CFG_RED) && q_big;
        do_done = (state_reg == mp3d_pkg::CFG_RED) && !q_big && !wr_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mp3d_pkg::CFG_IDLE;
            cam_reg   <= AW'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (do_done)
                cam_reg <= AW'(q_reg);
        end
    end

    // Divider and modulo reduction datapath.
    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            n_reg   <= 14'(cfg_reg.vol_x) + 14'(cfg_reg.pool_x) - 14'd1;
            q_reg   <= 14'd0;
            rem_reg <= 7'd0;
            cnt_reg <= 4'd0;
        end
        else if (do_step)
        begin
            n_reg   <= {n_reg[12:0], 1'b0};
            q_reg   <= {q_reg[12:0], ge};
            rem_reg <= ge ? 7'(rem_sh - {1'b0, cfg_reg.pool_x}) : rem_sh[6:0];
            cnt_reg <= cnt_reg + 4'd1;
        end
        else if (do_red)
        begin
            q_reg <= q_reg - 14'(MAX_PLANE_CELLS);
        end
    end

    assign cfg = cfg_reg;
    assign cam = cam_reg;

endmodule

`default_nettype wire

// File: rtl/mp3d_front.sv
// Front part: raster position counters, window classification, store address.
// Depends on mp3d_pkg.
`default_nettype none

module mp3d_front #(
    parameter int SAMPLE_BITS     = 16,
    parameter int MAX_PLANE_CELLS = 65536,
    parameter int MAX_POOL        = 64,
    parameter int MAX_EXTENT      = 4096
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [15:0]                s_tdata,
    input  wire logic                       s_tuser,
    input  wire mp3d_pkg::cfg_t             cfg,
    input  wire logic [((MAX_PLANE_CELLS > 2) ? $clog2(MAX_PLANE_CELLS) : 1)-1:0] cam,
    input  wire logic                       cfg_busy,
    input  wire logic                       q_full,
    output logic                            push,
    output logic [((MAX_PLANE_CELLS > 2) ? $clog2(MAX_PLANE_CELLS) : 1)-1:0] push_addr,
    output logic [SAMPLE_BITS-1:0]          push_sample,
    output mp3d_pkg::ctl_t                  push_ctl
);

    localparam int AW     = (MAX_PLANE_CELLS > 2) ? $clog2(MAX_PLANE_CELLS) : 1;
    localparam int VX_MAX = (MAX_EXTENT < 8191) ? MAX_EXTENT : 8191;
    localparam int CW     = (VX_MAX > 2) ? $clog2(VX_MAX) : 1;
    localparam int PMAX   = (MAX_POOL < 127) ? MAX_POOL : 127;
    localparam int PW     = (PMAX > 2) ? $clog2(PMAX) : 1;
    localparam logic [AW:0] MOD = (AW+1)'(MAX_PLANE_CELLS);

    // Addition of two residues modulo the store depth.
    function automatic logic [AW-1:0] mod_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= MOD)
            s = s - MOD;
        return s[AW-1:0];
    endfunction

    logic [CW-1:0] col_reg,  col_next,  e_col;
    logic [PW-1:0] cp_reg,   cp_next,   e_cp;
    logic [CW-1:0] cc_reg,   cc_next,   e_cc;
    logic [AW-1:0] ccm_reg,  ccm_next,  e_ccm;
    logic [CW-1:0] row_reg,  row_next,  e_row;
    logic [PW-1:0] rp_reg,   rp_next,   e_rp;
    logic [CW-1:0] cr_reg,   cr_next,   e_cr;
    logic [AW-1:0] rb_reg,   rb_next,   e_rb;
    logic [15:0]   sl_reg,   sl_next,   e_sl;
    logic [PW-1:0] sp_reg,   sp_next,   e_sp;
    logic [15:0]   cs_reg,   cs_next,   e_cs;

    logic x_end, y_end, z_end, wx_end, wy_end, wz_end;
    logic sov;

    assign s_tready = !cfg_busy && !q_full;
    assign push     = s_tvalid && s_tready;
    assign sov      = s_tuser;

    // A start mark clears the position before the voxel is placed.
    assign e_col = sov ? '0 : col_reg;
    assign e_cp  = sov ? '0 : cp_reg;
    assign e_cc  = sov ? '0 : cc_reg;
    assign e_ccm = sov ? '0 : ccm_reg;
    assign e_row = sov ? '0 : row_reg;
    assign e_rp  = sov ? '0 : rp_reg;
    assign e_cr  = sov ? '0 : cr_reg;
    assign e_rb  = sov ? '0 : rb_reg;
    assign e_sl  = sov ? '0 : sl_reg;
    assign e_sp  = sov ? '0 : sp_reg;
    assign e_cs  = sov ? '0 : cs_reg;

    // Edge of volume and edge of window along each axis.
    assign x_end  = 13'(e_col) >= (cfg.vol_x - 13'd1);
    assign y_end  = 13'(e_row) >= (cfg.vol_y - 13'd1);
    assign z_end  = e_sl >= (cfg.vol_z - 16'd1);
    assign wx_end = x_end || (7'(e_cp) >= (cfg.pool_x - 7'd1));
    assign wy_end = y_end || (7'(e_rp) >= (cfg.pool_y - 7'd1));
    assign wz_end = z_end || (7'(e_sp) >= (cfg.pool_z - 7'd1));

    // Queue word for this voxel.
    always_comb
    begin
        push_addr      = mod_add(e_rb, e_ccm);
        push_sample    = s_tdata[SAMPLE_BITS-1:0];
        push_ctl.first = (e_cp == '0) && (e_rp == '0) && (e_sp == '0);
        push_ctl.emit  = wx_end && wy_end && wz_end;
        push_ctl.last  = x_end && y_end && z_end;
        push_ctl.out_x = 12'(e_cc);
        push_ctl.out_y = 12'(e_cr);
        push_ctl.out_z = e_cs;
    end

    // Raster advance.
    always_comb
    begin
        col_next = col_reg;
        cp_next  = cp_reg;
        cc_next  = cc_reg;
        ccm_next = ccm_reg;
        row_next = row_reg;
        rp_next  = rp_reg;
        cr_next  = cr_reg;
        rb_next  = rb_reg;
        sl_next  = sl_reg;
        sp_next  = sp_reg;
        cs_next  = cs_reg;
        if (push)
        begin
            col_next = e_col;
            cp_next  = e_cp;
            cc_next  = e_cc;
            ccm_next = e_ccm;
            row_next = e_row;
            rp_next  = e_rp;
            cr_next  = e_cr;
            rb_next  = e_rb;
            sl_next  = e_sl;
            sp_next  = e_sp;
            cs_next  = e_cs;
            if (!x_end)
            begin
                col_next = e_col + CW'(1);
                if (wx_end)
                begin
                    cp_next  = '0;
                    cc_next  = e_cc + CW'(1);
                    ccm_next = mod_add(e_ccm, AW'(1));
                end
                else
                begin
                    cp_next = e_cp + PW'(1);
                end
            end
            else
            begin
                col_next = '0;
                cp_next  = '0;
                cc_next  = '0;
                ccm_next = '0;
                if (!y_end)
                begin
                    row_next = e_row + CW'(1);
                    if (wy_end)
                    begin
                        rp_next = '0;
                        cr_next = e_cr + CW'(1);
                        rb_next = mod_add(e_rb, cam);
                    end
                    else
                    begin
                        rp_next = e_rp + PW'(1);
                    end
                end
                else
                begin
                    row_next = '0;
                    rp_next  = '0;
                    cr_next  = '0;
                    rb_next  = '0;
                    if (!z_end)
                    begin
                        sl_next = e_sl + 16'd1;
                        if (wz_end)
                        begin
                            sp_next = '0;
                            cs_next = e_cs + 16'd1;
                        end
                        else
                        begin
                            sp_next = e_sp + PW'(1);
                        end
                    end
                    else
                    begin
                        sl_next = '0;
                        sp_next = '0;
                        cs_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            cp_reg  <= '0;
            cc_reg  <= '0;
            ccm_reg <= '0;
            row_reg <= '0;
            rp_reg  <= '0;
            cr_reg  <= '0;
            rb_reg  <= '0;
            sl_reg  <= '0;
            sp_reg  <= '0;
            cs_reg  <= '0;
        end
        else
        begin
            col_reg <= col_next;
            cp_reg  <= cp_next;
            cc_reg  <= cc_next;
            ccm_reg <= ccm_next;
            row_reg <= row_next;
            rp_reg  <= rp_next;
            cr_reg  <= cr_next;
            rb_reg  <= rb_next;
            sl_reg  <= sl_next;
            sp_reg  <= sp_next;
            cs_reg  <= cs_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/mp3d_queue.sv
// Short register queue between the front and the back part.
// Depends on mp3d_pkg.
`default_nettype none

module mp3d_queue #(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] wr_data,
    output logic              full,
    input  wire logic         pop,
    output logic              valid,
    output logic [W-1:0]      rd_data
);

    localparam int PW = mp3d_pkg::QUEUE_PTR_W;

    logic [W-1:0]  slot_reg [mp3d_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   cnt_reg, cnt_next;

    assign full    = (cnt_reg == (PW+1)'(mp3d_pkg::QUEUE_DEPTH));
    assign valid   = (cnt_reg != '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + (PW+1)'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - (PW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Slot storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

// File: rtl/mp3d_back.sv
// Back part: read-modify-write of the running maximum store and result register.
// Depends on mp3d_pkg.
`default_nettype none

module mp3d_back #(
    parameter int SAMPLE_BITS     = 16,
    parameter int MAX_PLANE_CELLS = 65536
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_valid,
    output logic                            q_pop,
    input  wire logic [((MAX_PLANE_CELLS > 2) ? $clog2(MAX_PLANE_CELLS) : 1)-1:0] q_addr,
    input  wire logic [SAMPLE_BITS-1:0]     q_sample,
    input  wire mp3d_pkg::ctl_t             q_ctl,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [55:0]                     m_tdata,
    output logic                            m_tlast
);

    localparam int AW = (MAX_PLANE_CELLS > 2) ? $clog2(MAX_PLANE_CELLS) : 1;

    logic [SAMPLE_BITS-1:0] mem [MAX_PLANE_CELLS];

    logic                   m_valid_reg, m_valid_next;
    logic [AW-1:0]          m_addr_reg;
    logic [SAMPLE_BITS-1:0] m_sample_reg;
    mp3d_pkg::ctl_t         m_ctl_reg;
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    logic                   lw_valid_reg;
    logic [AW-1:0]          lw_addr_reg;
    logic [SAMPLE_BITS-1:0] lw_data_reg;

    logic                   out_valid_reg, out_valid_next;
    logic [55:0]            out_data_reg;
    logic                   out_last_reg;

    logic                   out_free;
    logic                   m_adv;
    logic                   out_load;
    logic [SAMPLE_BITS-1:0] old_max;
    logic [SAMPLE_BITS-1:0] new_max;

    // Flow control through the modify stage and the result register.
    assign out_free = !out_valid_reg || m_tready;
    assign m_adv    = m_valid_reg && (!m_ctl_reg.emit || out_free);
    assign out_load = m_adv && m_ctl_reg.emit;
    assign q_pop    = q_valid && (!m_valid_reg || m_adv);

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (q_pop)
            m_valid_next = 1'b1;
        else if (m_adv)
            m_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // The write made at the edge of this word's read is not in the read data.
    assign old_max = (lw_valid_reg && (lw_addr_reg == m_addr_reg)) ? lw_data_reg : rd_data_reg;
    assign new_max = m_ctl_reg.first ? m_sample_reg :
                     ((m_sample_reg > old_max) ? m_sample_reg : old_max);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            lw_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg   <= m_valid_next;
            out_valid_reg <= out_valid_next;
            if (m_adv)
                lw_valid_reg <= 1'b1;
        end
    end

    // Store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (m_adv)
            mem[m_addr_reg] <= new_max;
        if (q_pop)
            rd_data_reg <= mem[q_addr];
    end

    // Modify stage payload, last-write bypass and result payload.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            m_addr_reg   <= q_addr;
            m_sample_reg <= q_sample;
            m_ctl_reg    <= q_ctl;
        end
        if (m_adv)
        begin
            lw_addr_reg <= m_addr_reg;
            lw_data_reg <= new_max;
        end
        if (out_load)
        begin
            out_data_reg <= {m_ctl_reg.out_z, m_ctl_reg.out_y, m_ctl_reg.out_x,
                             16'(new_max)};
            out_last_reg <= m_ctl_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/max_pool_3d_stream.sv
// Top level of the streaming 3D max pooling block.
// Depends on mp3d_pkg, mp3d_cfg, mp3d_front, mp3d_queue and mp3d_back.
//
//   Channel   Direction  Ports                               Payload
//   --------  ---------  ----------------------------------  ----------------------------
//   s_*       in         s_tvalid s_tready s_tdata s_tuser   voxel sample, volume start
//   m_*       out        m_tvalid m_tready m_tdata m_tlast   window max and cell indices
//   cfg_*     in         cfg_we cfg_index cfg_data           register write, no read-back
//
// One voxel word is taken every cycle unless the divider is busy or the queue is full;
// the store read-modify-write, with a bypass of the previous write, retires one word per
// cycle unless a result waits on a stalled output. A result passes the queue, the modify
// stage and the result register. After a register write s_tready stays low while the
// sequential divider derives the cells per row. Reset is asynchronous; the store is not
// cleared. A stalled m_tready holds the result register and backs up into the queue.
`default_nettype none

module max_pool_3d_stream #(
    parameter int SAMPLE_BITS     = 16,
    parameter int MAX_PLANE_CELLS = 65536,
    parameter int MAX_POOL        = 64,
    parameter int MAX_EXTENT      = 4096
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [15:0]                      s_tdata,  // [15:0] sample
    input  wire logic                             s_tuser,  // [0] start_of_volume
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [15:0] pooled_max, [27:16] out_x, [39:28] out_y, [55:40] out_z
    output logic [55:0]                           m_tdata,
    output logic                                  m_tlast,
    input  wire logic                             cfg_we,
    input  wire logic [mp3d_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mp3d_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW    = (MAX_PLANE_CELLS > 2) ? $clog2(MAX_PLANE_CELLS) : 1;
    localparam int CTL_W = $bits(mp3d_pkg::ctl_t);
    localparam int QW    = AW + SAMPLE_BITS + CTL_W;

    mp3d_pkg::cfg_t         cfg;
    logic [AW-1:0]          cam;
    logic                   cfg_busy;

    logic                   push;
    logic [AW-1:0]          push_addr;
    logic [SAMPLE_BITS-1:0] push_sample;
    mp3d_pkg::ctl_t         push_ctl;

    logic                   q_full;
    logic                   q_valid;
    logic                   q_pop;
    logic [QW-1:0]          q_wdata;
    logic [QW-1:0]          q_rdata;
    logic [AW-1:0]          q_addr;
    logic [SAMPLE_BITS-1:0] q_sample;
    mp3d_pkg::ctl_t         q_ctl;

    // Register file and cell count derivation.
    mp3d_cfg #(
        .MAX_PLANE_CELLS (MAX_PLANE_CELLS),
        .MAX_POOL        (MAX_POOL),
        .MAX_EXTENT      (MAX_EXTENT)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .cam       (cam),
        .busy      (cfg_busy)
    );

    // Position tracking and classification.
    mp3d_front #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .MAX_PLANE_CELLS (MAX_PLANE_CELLS),
        .MAX_POOL        (MAX_POOL),
        .MAX_EXTENT      (MAX_EXTENT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg         (cfg),
        .cam         (cam),
        .cfg_busy    (cfg_busy),
        .q_full      (q_full),
        .push        (push),
        .push_addr   (push_addr),
        .push_sample (push_sample),
        .push_ctl    (push_ctl)
    );

    // Queue word packing: control lowest, then sample, then address.
    assign q_wdata  = {push_addr, push_sample, push_ctl};
    assign q_ctl    = mp3d_pkg::ctl_t'(q_rdata[CTL_W-1:0]);
    assign q_sample = q_rdata[CTL_W +: SAMPLE_BITS];
    assign q_addr   = q_rdata[CTL_W + SAMPLE_BITS +: AW];

    mp3d_queue #(
        .W (QW)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .rd_data (q_rdata)
    );

    // Store update and result output.
    mp3d_back #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .MAX_PLANE_CELLS (MAX_PLANE_CELLS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_addr   (q_addr),
        .q_sample (q_sample),
        .q_ctl    (q_ctl),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// File: rtl/mp3d_checker.sv
// Port-level checks for the 3D max pooling stream block, bound to the top level.
// Depends on mp3d_pkg and max_pool_3d_stream.
`default_nettype none

module mp3d_port_checks (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [55:0]                      m_tdata,
    input  wire logic                             m_tlast,
    input  wire logic                             cfg_we,
    input  wire logic [mp3d_pkg::CFG_IDX_W-1:0]   cfg_index
);

    logic [31:0] in_cnt_reg;
    logic [31:0] out_cnt_reg;

    // Count accepted voxel words and delivered result words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_cnt_reg <= in_cnt_reg + 32'd1;
            if (m_tvalid && m_tready)
                out_cnt_reg <= out_cnt_reg + 32'd1;
        end
    end

    // A stalled result word holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // Every result word is caused by an earlier voxel word.
    a_out_caused: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |-> in_cnt_reg > out_cnt_reg)
        else $error("result word without a voxel word");

    // A register write holds off voxel words while the cell count is derived.
    a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && (cfg_index <= mp3d_pkg::REG_VOL_Z) |=> !s_tready)
        else $error("voxel word taken during cell count derivation");

    // No result word is shown while reset is held.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

endmodule

bind max_pool_3d_stream mp3d_port_checks u_checker (.*);

`default_nettype wire
